/* rtl/core/rtir_pkg.sv */
// ----------------------------------------------------------------------------
// rtir_pkg
// shared types, constants and arithmetic helpers of the rtn to inertial block
// ----------------------------------------------------------------------------
package rtir_pkg;

  // pipeline depths
  localparam int CROSS_LAT  = 2;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;
  localparam int NORM_LAT   = 3 + SQRT_STEPS + DIV_STEPS;
  localparam int ROT_LAT    = 4;
  localparam int FORCE_DLY  = CROSS_LAT + NORM_LAT;

  localparam logic signed [63:0] Q30_ONE  = 64'sd1 <<< 30;
  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< 29;
  localparam logic signed [63:0] ACC_MAX  = (64'sd1 <<< 33) - 64'sd1;
  localparam logic signed [63:0] ACC_MIN  = -(64'sd1 <<< 33);

  // one stage of the square root pipeline
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][29:0] m;
    logic [61:0]      rem;
    logic [30:0]      res;
  } rtir_sqrt_t;

  // one stage of the divider pipeline, three lanes share the divisor
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [30:0]      q;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] quo;
  } rtir_div_t;

  // shift that brings every magnitude below 2^30
  function automatic logic [5:0] norm_shift(logic [63:0] v);
    logic [6:0] len;
    len = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) len = 7'(i + 1);
    end
    norm_shift = (len > 7'd30) ? 6'(len - 7'd30) : 6'd0;
  endfunction

  // one result bit of the floor square root, rem holds x - res^2
  function automatic rtir_sqrt_t sqrt_step(rtir_sqrt_t s, int b);
    rtir_sqrt_t o;
    logic [63:0] t;
    o = s;
    t = (64'(s.res) << (b + 1)) + (64'd1 << (2 * b));
    if (64'(s.rem) >= t) begin
      o.rem = 62'(64'(s.rem) - t);
      o.res = s.res | (31'd1 << b);
    end
    sqrt_step = o;
  endfunction

  // one quotient bit for each lane
  function automatic rtir_div_t div_step(rtir_div_t d, logic first);
    rtir_div_t o;
    logic [31:0] r;
    o = d;
    for (int i = 0; i < 3; i++) begin
      r = first ? d.rem[i] : (d.rem[i] << 1);
      if (r >= 32'(d.q)) begin
        o.rem[i] = r - 32'(d.q);
        o.quo[i] = {d.quo[i][29:0], 1'b1};
      end else begin
        o.rem[i] = r;
        o.quo[i] = {d.quo[i][29:0], 1'b0};
      end
    end
    div_step = o;
  endfunction

  // divide by 2^30, nearest with ties away from zero
  function automatic logic signed [63:0] round30(logic signed [63:0] x);
    if (x < 0) round30 = (x + HALF_LSB - 64'sd1) >>> 30;
    else round30 = (x + HALF_LSB) >>> 30;
  endfunction

endpackage

/* rtl/core/rtn_to_inertial_rotation_top.sv */
// ----------------------------------------------------------------------------
// rtn_to_inertial_rotation_top
// rotates an empirical acceleration from radial/along/cross axes to inertial
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one item: inertial position (mm),
//   velocity (mm/s) and a force in radial, along-track, cross-track components
//   output channel out_valid/out_ready returns one item per input item: the
//   force in inertial axes and a degenerate flag (zero position or zero r x v,
//   with all acceleration components then zero)
//   the pipeline computes r x v, then the unit vectors (3 prescale and
//   square stages, 31 square root stages, 31 divider stages, one bit each),
//   then the along-track axis and the rotation, ending in the output reg
//   throughput is one item per cycle; the whole pipeline advances on one
//   enable, so the rate is set by the receiver alone
//   when the receiver stalls with a result waiting, every stage holds and
//   in_ready drops in the same cycle; nothing is lost or repeated
//   reset clears all valid bits; no reset for the data registers exists
// ----------------------------------------------------------------------------
module rtn_to_inertial_rotation_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [36:0] pos_x,
  input  logic signed [36:0] pos_y,
  input  logic signed [36:0] pos_z,
  input  logic signed [27:0] vel_x,
  input  logic signed [27:0] vel_y,
  input  logic signed [27:0] vel_z,
  input  logic signed [31:0] force_radial,
  input  logic signed [31:0] force_along,
  input  logic signed [31:0] force_cross,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [33:0] acc_x,
  output logic signed [33:0] acc_y,
  output logic signed [33:0] acc_z,
  output logic               degenerate
);

  // global advance: move when the output register is empty or being taken
  logic             en;
  logic             cr_valid;
  logic [2:0][63:0] r_mag, h_mag;
  logic [2:0]       r_neg, h_neg;
  logic             r_valid, h_valid, r_zero, h_zero;
  logic [2:0][31:0] ru, nu;
  // force delay line, lined up with the unit vectors
  logic [2:0][31:0] fdly [rtir_pkg::FORCE_DLY];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rtir_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .out_valid (cr_valid),
    .r_mag     (r_mag),
    .r_neg     (r_neg),
    .h_mag     (h_mag),
    .h_neg     (h_neg)
  );

  // radial axis
  rtir_norm u_norm_r (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cr_valid),
    .in_mag    (r_mag),
    .in_neg    (r_neg),
    .out_valid (r_valid),
    .out_zero  (r_zero),
    .out_unit  (ru)
  );

  // normal axis
  rtir_norm u_norm_h (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cr_valid),
    .in_mag    (h_mag),
    .in_neg    (h_neg),
    .out_valid (h_valid),
    .out_zero  (h_zero),
    .out_unit  (nu)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fdly[0][0] <= force_radial;
      fdly[0][1] <= force_along;
      fdly[0][2] <= force_cross;
      for (int k = 1; k < rtir_pkg::FORCE_DLY; k++) begin
        fdly[k] <= fdly[k - 1];
      end
    end
  end

  rtir_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_degen  (r_zero || h_zero),
    .ru        (ru),
    .nu        (nu),
    .force_rtn (fdly[rtir_pkg::FORCE_DLY - 1]),
    .out_valid (out_valid),
    .out_degen (degenerate),
    .acc_x     (acc_x),
    .acc_y     (acc_y),
    .acc_z     (acc_z)
  );

  // both normalizers must stay in lockstep
  a_norm_lockstep: assert property (@(posedge clk) disable iff (rst)
    r_valid == h_valid)
    else $error("radial and normal unit vectors out of step");

  // a degenerate frame gives no acceleration
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> acc_x == 34'sd0 && acc_y == 34'sd0 && acc_z == 34'sd0)
    else $error("degenerate item with nonzero acceleration");

  // a stalled output keeps the r x v and radial unit-vector valid bits frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(r_valid) && $stable(cr_valid))
    else $error("pipeline moved during a stall");

endmodule

/* rtl/core/rtir_cross.sv */
// ----------------------------------------------------------------------------
// rtir_cross
// angular momentum r x v and sign/magnitude split of position, two stages
// ----------------------------------------------------------------------------
module rtir_cross (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [36:0]      pos_x,
  input  logic signed [36:0]      pos_y,
  input  logic signed [36:0]      pos_z,
  input  logic signed [27:0]      vel_x,
  input  logic signed [27:0]      vel_y,
  input  logic signed [27:0]      vel_z,
  output logic                    out_valid,
  output logic [2:0][63:0]        r_mag,
  output logic [2:0]              r_neg,
  output logic [2:0][63:0]        h_mag,
  output logic [2:0]              h_neg
);

  logic                    c1_valid;
  logic signed [64:0]      prod [6];
  logic [2:0][63:0]        c1_rmag;
  logic [2:0]              c1_rneg;
  logic signed [64:0]      diff [3];

  // stage one: products
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= 65'(pos_y) * 65'(vel_z);
      prod[1] <= 65'(pos_z) * 65'(vel_y);
      prod[2] <= 65'(pos_z) * 65'(vel_x);
      prod[3] <= 65'(pos_x) * 65'(vel_z);
      prod[4] <= 65'(pos_x) * 65'(vel_y);
      prod[5] <= 65'(pos_y) * 65'(vel_x);
      c1_rneg <= {pos_z[36], pos_y[36], pos_x[36]};
      c1_rmag[0] <= 64'(pos_x[36] ? -38'(pos_x) : 38'(pos_x));
      c1_rmag[1] <= 64'(pos_y[36] ? -38'(pos_y) : 38'(pos_y));
      c1_rmag[2] <= 64'(pos_z[36] ? -38'(pos_z) : 38'(pos_z));
    end
  end

  // stage two: differences to sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = prod[2 * i] - prod[2 * i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_mag <= c1_rmag;
      r_neg <= c1_rneg;
      for (int i = 0; i < 3; i++) begin
        h_neg[i] <= diff[i][64];
        h_mag[i] <= diff[i][64] ? 64'(-diff[i]) : 64'(diff[i]);
      end
    end
  end

endmodule

/* rtl/core/rtir_norm.sv */
// ----------------------------------------------------------------------------
// rtir_norm
// unit vector in q1.30: prescale, squares, pipelined square root and divider
// ----------------------------------------------------------------------------
module rtir_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][63:0] in_mag,
  input  logic [2:0]       in_neg,
  output logic             out_valid,
  output logic             out_zero,
  output logic [2:0][31:0] out_unit
);

  logic             n1_valid, n2_valid, n3_valid;
  logic             n1_zero, n2_zero, n3_zero;
  logic [2:0]       n1_neg, n2_neg, n3_neg;
  logic [2:0][29:0] n1_m, n2_m, n3_m;
  logic [2:0][59:0] n2_sq;
  logic [61:0]      n3_sum;
  logic [5:0]       sh;

  rtir_pkg::rtir_sqrt_t sq_in;
  rtir_pkg::rtir_sqrt_t sq [rtir_pkg::SQRT_STEPS];
  rtir_pkg::rtir_div_t  dv_in;
  rtir_pkg::rtir_div_t  dv [rtir_pkg::DIV_STEPS];

  assign sh = rtir_pkg::norm_shift(in_mag[0] | in_mag[1] | in_mag[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
      n2_valid <= 1'b0;
      n3_valid <= 1'b0;
    end else if (en) begin
      n1_valid <= in_valid;
      n2_valid <= n1_valid;
      n3_valid <= n2_valid;
    end
  end

  // prescale, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      n1_zero <= (in_mag[0] == 64'd0) && (in_mag[1] == 64'd0) && (in_mag[2] == 64'd0);
      n1_neg  <= in_neg;
      for (int i = 0; i < 3; i++) begin
        n1_m[i] <= 30'(in_mag[i] >> sh);
      end
      n2_zero <= n1_zero;
      n2_neg  <= n1_neg;
      n2_m    <= n1_m;
      for (int i = 0; i < 3; i++) begin
        n2_sq[i] <= 60'(n1_m[i]) * 60'(n1_m[i]);
      end
      n3_zero <= n2_zero;
      n3_neg  <= n2_neg;
      n3_m    <= n2_m;
      n3_sum  <= 62'(n2_sq[0]) + 62'(n2_sq[1]) + 62'(n2_sq[2]);
    end
  end

  always_comb begin
    sq_in.valid = n3_valid;
    sq_in.zero  = n3_zero;
    sq_in.neg   = n3_neg;
    sq_in.m     = n3_m;
    sq_in.rem   = n3_sum;
    sq_in.res   = '0;
  end

  // square root, most significant result bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rtir_pkg::SQRT_STEPS; k++) begin
        sq[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < rtir_pkg::SQRT_STEPS; k++) begin
        sq[k] <= rtir_pkg::sqrt_step((k == 0) ? sq_in : sq[(k == 0) ? 0 : k - 1],
                                     rtir_pkg::SQRT_STEPS - 1 - k);
      end
    end
  end

  // divisor never zero, a zero vector is flagged anyway
  always_comb begin
    dv_in.valid = sq[rtir_pkg::SQRT_STEPS - 1].valid;
    dv_in.zero  = sq[rtir_pkg::SQRT_STEPS - 1].zero;
    dv_in.neg   = sq[rtir_pkg::SQRT_STEPS - 1].neg;
    dv_in.q     = (sq[rtir_pkg::SQRT_STEPS - 1].res == 31'd0) ? 31'd1 :
                  sq[rtir_pkg::SQRT_STEPS - 1].res;
    for (int i = 0; i < 3; i++) begin
      dv_in.rem[i] = 32'(sq[rtir_pkg::SQRT_STEPS - 1].m[i]);
      dv_in.quo[i] = '0;
    end
  end

  // (m << 30) / q, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rtir_pkg::DIV_STEPS; k++) begin
        dv[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < rtir_pkg::DIV_STEPS; k++) begin
        dv[k] <= rtir_pkg::div_step((k == 0) ? dv_in : dv[(k == 0) ? 0 : k - 1], k == 0);
      end
    end
  end

  assign out_valid = dv[rtir_pkg::DIV_STEPS - 1].valid;
  assign out_zero  = dv[rtir_pkg::DIV_STEPS - 1].zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_unit[i] = dv[rtir_pkg::DIV_STEPS - 1].neg[i] ?
                    -{1'b0, dv[rtir_pkg::DIV_STEPS - 1].quo[i]} :
                    {1'b0, dv[rtir_pkg::DIV_STEPS - 1].quo[i]};
    end
  end

endmodule

/* rtl/core/rtir_rot.sv */
// ----------------------------------------------------------------------------
// rtir_rot
// along-track vector t = n x r and rotation of the force into inertial axes
// ----------------------------------------------------------------------------
module rtir_rot (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                in_degen,
  input  logic [2:0][31:0]    ru,
  input  logic [2:0][31:0]    nu,
  input  logic [2:0][31:0]    force_rtn,
  output logic                out_valid,
  output logic                out_degen,
  output logic signed [33:0]  acc_x,
  output logic signed [33:0]  acc_y,
  output logic signed [33:0]  acc_z
);

  logic               t1_valid, t2_valid, a1_valid;
  logic               t1_degen, t2_degen, a1_degen;
  logic signed [63:0] tp [6];
  logic [2:0][31:0]   t1_ru, t1_nu, t1_f, t2_ru, t2_nu, t2_f, t2_tu;
  logic signed [63:0] ap [9];
  logic signed [63:0] tdiff [3];
  logic signed [63:0] tr [3];
  logic signed [63:0] asum [3];
  logic signed [63:0] ar [3];
  logic signed [33:0] acc_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      a1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      t1_valid  <= in_valid;
      t2_valid  <= t1_valid;
      a1_valid  <= t2_valid;
      out_valid <= a1_valid;
    end
  end

  // cross product terms of n x r
  always_ff @(posedge clk) begin
    if (en) begin
      tp[0]    <= 64'($signed(nu[1])) * 64'($signed(ru[2]));
      tp[1]    <= 64'($signed(nu[2])) * 64'($signed(ru[1]));
      tp[2]    <= 64'($signed(nu[2])) * 64'($signed(ru[0]));
      tp[3]    <= 64'($signed(nu[0])) * 64'($signed(ru[2]));
      tp[4]    <= 64'($signed(nu[0])) * 64'($signed(ru[1]));
      tp[5]    <= 64'($signed(nu[1])) * 64'($signed(ru[0]));
      t1_ru    <= ru;
      t1_nu    <= nu;
      t1_f     <= force_rtn;
      t1_degen <= in_degen;
    end
  end

  // round to q1.30 and clamp to +-1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tdiff[i] = tp[2 * i] - tp[2 * i + 1];
      tr[i]    = rtir_pkg::round30(tdiff[i]);
      if (tr[i] > rtir_pkg::Q30_ONE) tr[i] = rtir_pkg::Q30_ONE;
      else if (tr[i] < -rtir_pkg::Q30_ONE) tr[i] = -rtir_pkg::Q30_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t2_tu[i] <= tr[i][31:0];
      end
      t2_ru    <= t1_ru;
      t2_nu    <= t1_nu;
      t2_f     <= t1_f;
      t2_degen <= t1_degen;
    end
  end

  // products of the frame axes with the force components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ap[3 * i]     <= 64'($signed(t2_ru[i])) * 64'($signed(t2_f[0]));
        ap[3 * i + 1] <= 64'($signed(t2_tu[i])) * 64'($signed(t2_f[1]));
        ap[3 * i + 2] <= 64'($signed(t2_nu[i])) * 64'($signed(t2_f[2]));
      end
      a1_degen <= t2_degen;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum[i] = ap[3 * i] + ap[3 * i + 1] + ap[3 * i + 2];
      ar[i]   = rtir_pkg::round30(asum[i]);
      if (a1_degen) acc_next[i] = '0;
      else if (ar[i] > rtir_pkg::ACC_MAX) acc_next[i] = 34'(rtir_pkg::ACC_MAX);
      else if (ar[i] < rtir_pkg::ACC_MIN) acc_next[i] = 34'(rtir_pkg::ACC_MIN);
      else acc_next[i] = ar[i][33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_x     <= acc_next[0];
      acc_y     <= acc_next[1];
      acc_z     <= acc_next[2];
      out_degen <= a1_degen;
    end
  end

endmodule
